// ----- sv/pidd_pkg.sv -----
package pidd_pkg;

    localparam int FracBits   = 16;
    localparam int DataW      = 32;
    localparam int DtW        = 16;
    localparam int UsPerS     = 1000000;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 32;

    typedef enum logic [2:0] {
        CFG_P_GAIN     = 3'd0,
        CFG_I_GAIN     = 3'd1,
        CFG_D_GAIN     = 3'd2,
        CFG_SET_POINT  = 3'd3,
        CFG_SP_SHIFT   = 3'd4,
        CFG_INT_LIMIT  = 3'd5,
        CFG_DEAD_BAND  = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_IMUL,
        ST_IDIV,
        ST_ICLAMP,
        ST_DMUL,
        ST_DDIV,
        ST_PMUL,
        ST_IMULG,
        ST_DMULG,
        ST_OUT
    } t_state;

    // shift-add multiplier and divider request / status
    typedef struct packed {
        logic start;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ----- sv/pid_controller_deadband.sv -----
// pid controller with deadband and integral clamp, fixed point with
// FRAC_BITS fraction bits
//
// channels: s_axis takes one sample (tdata bits 31:0 measured_value,
// 47:32 time_delta_us); m_axis gives one result per sample (tdata bits
// 31:0 control_out, 63:32 error_now; tuser priming_sample). gains, set
// point, shift, integral limit and dead band are written through i_cfg_*;
// the user must do so only while the block is idle; the block does not enforce it.
//
// one sample is worked at a time by a bit-serial multiplier and a
// bit-serial divider, one bit per cycle: integral step (multiply, then
// divide), derivative step (multiply, then divide), then three gain
// products, plus a state each for error, clamp and output. the priming
// sample (first after reset) skips these steps; its result is registered as it is taken.
// s_axis_tready is high only in idle: no new sample until the last is done.
//
// reset clears the integral, both errors, the primed flag and all
// configuration. a stalled result sits in the output register until
// taken; the next sample is accepted in the same cycle it leaves.
module pid_controller_deadband import pidd_pkg::*; #(
    parameter int FRAC_BITS = FracBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // measured_value, time_delta_us
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // control_out, error_now
    output logic                 m_axis_tuser,   // priming_sample
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgDataW-1:0]  i_cfg_data
);
    localparam int NW = 56;  // 33-bit error x 1e6 fits
    localparam int DW = 21;  // 1e6 fits
    localparam logic signed [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
    localparam logic signed [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

    // configuration
    logic signed [DataW-1:0] r_p_gain, r_i_gain, r_d_gain, r_sp, r_sp_shift;
    logic [DataW-2:0]        r_int_lim, r_dead_band;

    // state
    logic signed [DataW-1:0] r_integ, r_err, r_prev_err, r_deriv;
    logic                    r_primed;
    logic signed [DataW-1:0] r_meas;
    logic [DtW-1:0]          r_dt;
    logic signed [67:0]      r_sum;

    logic [DataW-1:0]        r_out_ctrl, r_out_err;
    logic                    r_out_prime, r_out_valid;
    logic                    w_out_load;

    t_state r_state, n_state;

    // shared multiplier: 33-bit signed a, 32-bit b
    t_mul_ctl                w_mctl, w_dctl;
    t_unit_sts               w_msts, w_dsts;
    logic signed [32:0]      w_ma;
    logic signed [31:0]      w_mb;
    logic signed [64:0]      w_mp;
    logic signed [NW-1:0]    w_dnum;
    logic [DW-1:0]           w_dden;
    logic signed [NW-1:0]    w_dq;

    pidd_mul #(.AW(33), .BW(32)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mctl),
        .i_a(w_ma), .i_b(w_mb), .o_sts(w_msts), .o_p(w_mp)
    );

    pidd_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl),
        .i_num(w_dnum), .i_den(w_dden), .o_sts(w_dsts), .o_q(w_dq)
    );

    logic signed [33:0] w_raw;
    logic [33:0]        w_mag;
    logic signed [32:0] w_ediff;
    logic signed [NW-1:0] w_iq_next;
    logic signed [33:0] w_integ_new;
    logic signed [32:0] w_lim;
    logic signed [NW-1:0] w_dq_sat;
    logic signed [67:0] w_term;
    logic signed [DataW-1:0] w_err_new;

    assign w_raw   = 34'(r_sp) + 34'(r_sp_shift) - 34'(r_meas);
    assign w_mag   = w_raw[33] ? 34'(-w_raw) : 34'(w_raw);
    assign w_ediff = 33'(r_err) - 33'(r_prev_err);
    assign w_lim   = 33'({1'b0, r_int_lim});
    assign w_integ_new = 34'(r_integ) + 34'(w_dq);
    assign w_term  = 68'(w_mp >>> FRAC_BITS);

    always_comb begin
        if (w_mag <= 34'(r_dead_band))      w_err_new = '0;
        else if (w_raw > 34'(SMax))         w_err_new = SMax;
        else if (w_raw < 34'(SMin))         w_err_new = SMin;
        else                                w_err_new = w_raw[DataW-1:0];
    end

    always_comb begin
        w_mctl.start = 1'b0;
        w_dctl.start = 1'b0;
        w_ma = 33'(r_err);
        w_mb = 32'(r_dt);
        w_dnum = NW'(w_mp);
        w_dden = DW'(UsPerS);
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready && r_primed) n_state = ST_ERR;
            end
            ST_ERR: begin
                w_ma = 33'(w_err_new);
                w_mb = 32'(r_dt);
                w_mctl.start = 1'b1;
                n_state = ST_IMUL;
            end
            ST_IMUL: begin
                if (w_msts.done) begin
                    w_dctl.start = 1'b1;
                    n_state = ST_IDIV;
                end
            end
            ST_IDIV: if (w_dsts.done) n_state = ST_ICLAMP;
            ST_ICLAMP: begin
                w_ma = w_ediff;
                w_mb = 32'(UsPerS);
                w_mctl.start = 1'b1;
                n_state = ST_DMUL;
            end
            ST_DMUL: begin
                w_dden = DW'(r_dt);
                if (w_msts.done) begin
                    w_dctl.start = 1'b1;
                    n_state = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (w_dsts.done) begin
                    w_ma = 33'(r_err);
                    w_mb = r_p_gain;
                    w_mctl.start = 1'b1;
                    n_state = ST_PMUL;
                end
            end
            ST_PMUL: begin
                if (w_msts.done) begin
                    w_ma = 33'(r_integ);
                    w_mb = r_i_gain;
                    w_mctl.start = 1'b1;
                    n_state = ST_IMULG;
                end
            end
            ST_IMULG: begin
                if (w_msts.done) begin
                    w_ma = 33'(r_deriv);
                    w_mb = r_d_gain;
                    w_mctl.start = 1'b1;
                    n_state = ST_DMULG;
                end
            end
            ST_DMULG: if (w_msts.done) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign w_dq_sat = w_dq;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);

    // output register loads a new result this cycle
    assign w_out_load = (s_axis_tvalid && s_axis_tready && !r_primed) ||
                        ((r_state == ST_OUT) && (!r_out_valid || m_axis_tready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_primed    <= 1'b0;
            r_integ     <= '0;
            r_err       <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
            r_p_gain    <= '0;
            r_i_gain    <= '0;
            r_d_gain    <= '0;
            r_sp        <= '0;
            r_sp_shift  <= '0;
            r_int_lim   <= '0;
            r_dead_band <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready && !w_out_load) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_P_GAIN:    r_p_gain    <= i_cfg_data;
                    CFG_I_GAIN:    r_i_gain    <= i_cfg_data;
                    CFG_D_GAIN:    r_d_gain    <= i_cfg_data;
                    CFG_SET_POINT: r_sp        <= i_cfg_data;
                    CFG_SP_SHIFT:  r_sp_shift  <= i_cfg_data;
                    CFG_INT_LIMIT: r_int_lim   <= i_cfg_data[DataW-2:0];
                    CFG_DEAD_BAND: r_dead_band <= i_cfg_data[DataW-2:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                r_meas <= s_axis_tdata[31:0];
                // zero time delta counts as one
                r_dt   <= (s_axis_tdata[47:32] == '0) ? DtW'(1) : s_axis_tdata[47:32];
                if (!r_primed) begin
                    // priming sample: report current error, output zero
                    r_primed    <= 1'b1;
                    r_prev_err  <= r_err;
                    r_out_ctrl  <= '0;
                    r_out_err   <= r_err;
                    r_out_prime <= 1'b1;
                    r_out_valid <= 1'b1;
                end
            end

            unique case (r_state)
                ST_ERR: r_err <= w_err_new;
                ST_IDIV: begin
                    if (w_dsts.done) begin
                        // clamp to +/- limit
                        if (w_integ_new > 34'(w_lim))       r_integ <= w_lim[DataW-1:0];
                        else if (w_integ_new < 34'(-w_lim)) r_integ <= 32'(-w_lim);
                        else                                r_integ <= w_integ_new[DataW-1:0];
                    end
                end
                ST_DDIV: begin
                    if (w_dsts.done) begin
                        if (w_dq_sat > NW'(SMax))      r_deriv <= SMax;
                        else if (w_dq_sat < NW'(SMin)) r_deriv <= SMin;
                        else                           r_deriv <= w_dq_sat[DataW-1:0];
                    end
                end
                ST_PMUL:  if (w_msts.done) r_sum <= w_term;
                ST_IMULG: if (w_msts.done) r_sum <= r_sum + w_term;
                ST_DMULG: if (w_msts.done) r_sum <= r_sum + w_term;
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        if (r_sum > 68'(SMax))      r_out_ctrl <= SMax;
                        else if (r_sum < 68'(SMin)) r_out_ctrl <= SMin;
                        else                        r_out_ctrl <= r_sum[DataW-1:0];
                        r_out_err   <= r_err;
                        r_out_prime <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_prev_err  <= r_err;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_err, r_out_ctrl};
    assign m_axis_tuser  = r_out_prime;

    // units never run at once
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_msts.busy && w_dsts.busy))
        else $error("multiplier and divider busy together");

    // input only taken in idle
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (r_state == ST_IDLE))
        else $error("sample taken while busy");

    // priming result comes out next cycle
    a_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !r_primed) |=> (r_out_valid && r_out_prime))
        else $error("priming result missing");
endmodule

// ----- sv/pidd_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
module pidd_mul import pidd_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_ctl                 i_ctl,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output t_unit_sts                o_sts,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int CW = $clog2(BW + 1);

    logic signed [AW+BW-1:0] r_acc, n_acc;
    logic signed [AW+BW-1:0] r_mcand, n_mcand;
    logic [BW-1:0]           r_mplier, n_mplier;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_ctl.start) begin
            n_acc    = '0;
            n_mcand  = (AW+BW)'(i_a);
            n_mplier = i_b;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            // top multiplier bit carries negative weight
            if (r_mplier[0]) begin
                if (r_cnt == CW'(BW - 1)) n_acc = r_acc - r_mcand;
                else                      n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand <<< 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + CW'(1);
            if (r_cnt == CW'(BW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_p        = r_acc;
endmodule

// ----- sv/pidd_div.sv -----
// restoring divider on magnitudes, one quotient bit per cycle, truncates toward zero
module pidd_div import pidd_pkg::*; #(
    parameter int NW = 56,
    parameter int DW = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_ctl              i_ctl,
    input  logic signed [NW-1:0]  i_num,
    input  logic [DW-1:0]         i_den,
    output t_unit_sts             o_sts,
    output logic signed [NW-1:0]  o_q
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DW-1:0], r_quo[NW-1]};
        if (i_ctl.start) begin
            n_neg  = i_num[NW-1];
            n_quo  = i_num[NW-1] ? (~i_num + NW'(1)) : i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = r_quo << 1;
            if (w_trial >= {1'b0, r_den}) begin
                n_rem    = w_trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_trial;
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_q        = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule
